// File: rtl/lltc_pkg.sv
// Shared types, constants and helpers for the LCD line timing controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package lltc_pkg;

  localparam int unsigned ClkW  = 9;
  localparam int unsigned LineW = 8;
  localparam int unsigned DotW  = 8;
  localparam int unsigned IdxW  = 2;
  localparam int unsigned CfgDW = 8;
  localparam int unsigned OutDW = 16;

  localparam logic [ClkW-1:0]  DotsPerLine     = 9'd456;
  localparam logic [LineW-1:0] LastLine        = 8'd153;
  localparam logic [LineW-1:0] FirstVblankLine = 8'd144;
  localparam logic [ClkW-1:0]  HblankStart     = 9'd252;
  localparam logic [ClkW-1:0]  TransferStart   = 9'd80;

  // register indexes
  localparam logic [IdxW-1:0] RegDisplayEnable = 2'd0;
  localparam logic [IdxW-1:0] RegLineCompare   = 2'd1;
  localparam logic [IdxW-1:0] RegStatEnables   = 2'd2;

  // lcd modes
  localparam logic [1:0] ModeHblank   = 2'd0;
  localparam logic [1:0] ModeVblank   = 2'd1;
  localparam logic [1:0] ModeSearch   = 2'd2;
  localparam logic [1:0] ModeTransfer = 2'd3;

  // stat enable bits
  localparam int unsigned StatHblank   = 0;
  localparam int unsigned StatVblank   = 1;
  localparam int unsigned StatLine     = 2;
  localparam int unsigned StatCoincide = 3;

  typedef struct packed {
    logic             display_enable;
    logic [LineW-1:0] line_compare;
    logic [3:0]       stat_irq_enables;
  } cfg_t;

  typedef struct packed {
    logic             draw_line;
    logic             hblank_event;
    logic             vblank_irq;
    logic             stat_irq;
    logic             coincide_flag;
    logic [1:0]       disp_mode;
    logic [LineW-1:0] current_line;
  } result_t;

  function automatic logic [1:0] mode_of(input logic [LineW-1:0] line,
                                         input logic [ClkW-1:0] clk);
    logic [1:0] m;
    if (line >= FirstVblankLine) begin
      m = ModeVblank;
    end else if (clk >= HblankStart) begin
      m = ModeHblank;
    end else if (clk >= TransferStart) begin
      m = ModeTransfer;
    end else begin
      m = ModeSearch;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lltc_core.sv
// Timing state (dot clock, line, coincidence, mode) and the one-step update.
// Depends on lltc_pkg.
`default_nettype none

module lltc_core
  import lltc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [DotW-1:0] dot_cycles_i,
  input  wire cfg_t            cfg_i,
  output result_t              res_o
);

  logic [ClkW-1:0]  line_clock_q, line_clock_d;
  logic [LineW-1:0] line_count_q, line_count_d;
  logic             coincide_q, coincide_d;
  logic [1:0]       mode_q, mode_d;

  logic [ClkW:0]    sum;
  logic             wrap;
  logic [LineW-1:0] line_inc;
  logic             match;
  logic             hbl, vbl, draw, stat;

  always_comb begin
    sum      = {1'b0, line_clock_q} + {2'b0, dot_cycles_i};
    wrap     = sum >= {1'b0, DotsPerLine};
    line_inc = line_count_q + 8'd1;

    line_clock_d = line_clock_q;
    line_count_d = line_count_q;
    coincide_d   = coincide_q;
    mode_d       = mode_q;
    match        = 1'b0;
    hbl          = 1'b0;
    vbl          = 1'b0;
    draw         = 1'b0;
    stat         = 1'b0;

    if (cfg_i.display_enable) begin
      if (wrap) begin
        line_clock_d = ClkW'(sum - {1'b0, DotsPerLine});
        line_count_d = (line_inc > LastLine) ? '0 : line_inc;
        match        = line_count_d == cfg_i.line_compare;
        coincide_d   = match;
      end else begin
        line_clock_d = sum[ClkW-1:0];
      end
      mode_d = mode_of(line_count_d, line_clock_d);

      hbl  = (line_clock_q < HblankStart) && (line_clock_d >= HblankStart) &&
             (line_count_d < FirstVblankLine);
      vbl  = wrap && (line_count_d == FirstVblankLine);
      draw = wrap && (line_count_d < FirstVblankLine);
      stat = (hbl && cfg_i.stat_irq_enables[StatHblank]) ||
             (vbl && cfg_i.stat_irq_enables[StatVblank]) ||
             (draw && cfg_i.stat_irq_enables[StatLine]) ||
             (wrap && match && cfg_i.stat_irq_enables[StatCoincide]);
    end

    res_o.current_line  = line_count_d;
    res_o.disp_mode     = mode_d;
    res_o.coincide_flag = coincide_d;
    res_o.stat_irq      = stat;
    res_o.vblank_irq    = vbl;
    res_o.hblank_event  = hbl;
    res_o.draw_line     = draw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_clock_q <= '0;
      line_count_q <= '0;
      coincide_q   <= 1'b0;
      mode_q       <= ModeHblank;
    end else if (step_i) begin
      line_clock_q <= line_clock_d;
      line_count_q <= line_count_d;
      coincide_q   <= coincide_d;
      mode_q       <= mode_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lcd_line_timing_controller.sv
// Top level: stream ports, config registers, input and result registers.
// Depends on lltc_pkg and lltc_core.
`default_nettype none

// LCD line timing controller. Each word on the slave stream carries a dot
// count; the block advances its dot clock (wrap at 456 dots, lines 0..153),
// and returns one result word per input word with the new line, lcd mode,
// sticky coincidence flag and the stat, vblank, hblank and draw-line events.
// Throughput is one word per clock while m_axis_tready is high: an input
// register feeds one pass of update logic into a result register, and the
// next word is taken into an empty input register while a result waits for
// tready; m_axis_tvalid rises once a word moves into a free result register.
// Config writes (index 0 display enable, 1 line compare, 2 stat enables,
// others ignored) are always ready and must be made while the block is idle.

module lcd_line_timing_controller
  import lltc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [DotW-1:0]  s_axis_tdata_i,   // [7:0] dot_cycles
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // [7:0] current_line, [9:8] disp_mode, [10] coincide_flag, [11] stat_irq,
  // [12] vblank_irq, [13] hblank_event, [14] draw_line, [15] zero
  output logic [OutDW-1:0]      m_axis_tdata_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [IdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDW-1:0] cfg_data_i
);

  cfg_t            cfg_q;
  logic            in_vld_q;
  logic [DotW-1:0] in_dot_q;
  logic            out_vld_q;
  result_t         out_q;
  result_t         res;
  logic            advance;

  assign cfg_ready_o     = 1'b1;
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDisplayEnable: cfg_q.display_enable   <= cfg_data_i[0];
        RegLineCompare:   cfg_q.line_compare     <= cfg_data_i;
        RegStatEnables:   cfg_q.stat_irq_enables <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_dot_q <= s_axis_tdata_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  lltc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .dot_cycles_i (in_dot_q),
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

`ifndef SYNTH
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_q.current_line <= LastLine)
    else $error("line out of range");

  a_vblank_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_q.vblank_irq) |->
      (out_q.disp_mode == ModeVblank && out_q.current_line == FirstVblankLine))
    else $error("vblank event without vblank mode");

  a_hblank_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_q.hblank_event) |-> out_q.disp_mode == ModeHblank)
    else $error("hblank event outside hblank mode");

  a_stat_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.stat_irq |-> cfg_q.display_enable && cfg_q.stat_irq_enables != 4'd0)
    else $error("stat irq with nothing enabled");
`endif

endmodule

`default_nettype wire
